[hw/rtl/lkws_pkg.sv]
// ----------------------------------------------------------------------------
// lkws_pkg
// Shared types, widths and command codes of the window flow solver.
// ----------------------------------------------------------------------------
package lkws_pkg;

  localparam int GRAD_W      = 12;
  localparam int FLOW_W      = 32;
  localparam int LIMIT_W     = 57;
  localparam int FRAC_W      = 16;
  localparam int MAX_WINDOW_DEF = 64;

  // operand pair of the shared solve multiplier
  localparam logic [2:0] MS_XX_YY = 3'd0;
  localparam logic [2:0] MS_XY_XY = 3'd1;
  localparam logic [2:0] MS_XY_YT = 3'd2;
  localparam logic [2:0] MS_YY_XT = 3'd3;
  localparam logic [2:0] MS_XY_XT = 3'd4;
  localparam logic [2:0] MS_XX_YT = 3'd5;

  // what the accumulator does with the registered product
  localparam logic [2:0] AO_NONE = 3'd0;
  localparam logic [2:0] AO_LOAD = 3'd1;
  localparam logic [2:0] AO_DET  = 3'd2;
  localparam logic [2:0] AO_NU   = 3'd3;
  localparam logic [2:0] AO_NV   = 3'd4;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_t;
    logic                     last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic                     solved;
  } out_item_t;

  typedef struct packed {
    logic       accumulate;
    logic       clear;
    logic [2:0] mul_sel;
    logic [2:0] acc_op;
    logic       div_start;
    logic       div_sel;
    logic       store_zero;
    logic       store_x;
    logic       store_y;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic singular;
    logic div_done;
  } status_t;

endpackage

[hw/rtl/lkws_div.sv]
// ----------------------------------------------------------------------------
// lkws_div
// Iterative restoring divider: signed numerator over unsigned denominator,
// Q16.16 quotient truncated toward zero and saturated, one bit per cycle.
// ----------------------------------------------------------------------------
module lkws_div
  import lkws_pkg::*;
#(
  parameter int NUM_W = 61,
  parameter int DEN_W = 57
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic                     flip,
  input  logic        [DEN_W-1:0]  den,
  output logic                     done,
  output logic signed [FLOW_W-1:0] quo
);

  localparam int CMP_W = (NUM_W > DEN_W + FRAC_W) ? NUM_W : DEN_W + FRAC_W;
  localparam int CNT_W = $clog2(FLOW_W);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PREP = 2'd1;
  localparam logic [1:0] PH_ITER = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  localparam logic [FLOW_W-1:0] Q_MAX = {1'b0, {(FLOW_W-1){1'b1}}};
  localparam logic [FLOW_W-1:0] Q_MIN = {1'b1, {(FLOW_W-1){1'b0}}};

  logic [1:0]        phase;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  nmag;
  logic [DEN_W-1:0]  dn;
  logic [DEN_W-1:0]  rem;
  logic [FLOW_W-1:0] sh;
  logic [FLOW_W-1:0] q;
  logic              neg;
  logic              sat;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, sh[FLOW_W-1]};
  assign fits  = trial >= {1'b0, dn};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_PREP;
          end
        end
        PH_PREP: phase <= PH_ITER;
        PH_ITER: begin
          if (cnt == CNT_W'(FLOW_W - 1)) begin
            phase <= PH_FIN;
          end
        end
        PH_FIN: begin
          phase <= PH_IDLE;
          done  <= 1'b1;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      PH_IDLE: begin
        nmag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        neg  <= num[NUM_W-1] ^ flip;
        dn   <= den;
      end
      PH_PREP: begin
        // integer part of 2^16 or more saturates
        sat <= CMP_W'(nmag) >= (CMP_W'(dn) << FRAC_W);
        rem <= DEN_W'(nmag >> FRAC_W);
        sh  <= {nmag[FRAC_W-1:0], {(FLOW_W-FRAC_W){1'b0}}};
        q   <= '0;
        cnt <= '0;
      end
      PH_ITER: begin
        rem <= fits ? DEN_W'(trial - {1'b0, dn}) : DEN_W'(trial);
        q   <= {q[FLOW_W-2:0], fits};
        sh  <= {sh[FLOW_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      PH_FIN: begin
        if (sat) begin
          quo <= neg ? Q_MIN : Q_MAX;
        end else if (neg) begin
          quo <= (q > Q_MIN) ? Q_MIN : -q;
        end else begin
          quo <= q[FLOW_W-1] ? Q_MAX : q;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/lkws_datapath.sv]
// ----------------------------------------------------------------------------
// lkws_datapath
// Window sums, shared solve multiplier with accumulator, singular test,
// divider and the result and output registers.
// ----------------------------------------------------------------------------
module lkws_datapath
  import lkws_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  output out_item_t          out_data
);

  localparam int LOG_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 2 * GRAD_W + LOG_W;
  localparam int PRD_W = 2 * SUM_W;
  localparam int ACC_W = PRD_W + 1;
  localparam int DET_W = PRD_W - 3;
  localparam int CMP_W = (DET_W > LIMIT_W) ? DET_W : LIMIT_W;

  logic [LIMIT_W-1:0]        limit;
  logic [CNT_W-1:0]          count;
  logic signed [SUM_W-1:0]   sum_xx, sum_xy, sum_yy, sum_xt, sum_yt;
  logic signed [2*GRAD_W-1:0] p_xx, p_xy, p_yy, p_xt, p_yt;
  logic signed [SUM_W-1:0]   op_a, op_b;
  logic signed [PRD_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc, det, nu, nv, prod_ext, diff;
  logic [DET_W-1:0]          adet;
  logic                      det_neg;
  logic signed [FLOW_W-1:0]  quo;
  logic signed [FLOW_W-1:0]  res_x, res_y;
  logic                      res_solved;
  logic                      singular;
  logic                      div_done;

  assign p_xx = in_data.grad_x * in_data.grad_x;
  assign p_xy = in_data.grad_x * in_data.grad_y;
  assign p_yy = in_data.grad_y * in_data.grad_y;
  assign p_xt = in_data.grad_x * in_data.grad_t;
  assign p_yt = in_data.grad_y * in_data.grad_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count  <= '0;
      sum_xx <= '0;
      sum_xy <= '0;
      sum_yy <= '0;
      sum_xt <= '0;
      sum_yt <= '0;
    end else if (cmd.accumulate && count < CNT_W'(MAX_WINDOW)) begin
      count  <= count + 1'b1;
      sum_xx <= sum_xx + SUM_W'(p_xx);
      sum_xy <= sum_xy + SUM_W'(p_xy);
      sum_yy <= sum_yy + SUM_W'(p_yy);
      sum_xt <= sum_xt + SUM_W'(p_xt);
      sum_yt <= sum_yt + SUM_W'(p_yt);
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MS_XX_YY: begin op_a = sum_xx; op_b = sum_yy; end
      MS_XY_XY: begin op_a = sum_xy; op_b = sum_xy; end
      MS_XY_YT: begin op_a = sum_xy; op_b = sum_yt; end
      MS_YY_XT: begin op_a = sum_yy; op_b = sum_xt; end
      MS_XY_XT: begin op_a = sum_xy; op_b = sum_xt; end
      MS_XX_YT: begin op_a = sum_xx; op_b = sum_yt; end
      default:  begin op_a = sum_xx; op_b = sum_yy; end
    endcase
  end

  assign prod_ext = ACC_W'(prod);
  assign diff     = acc - prod_ext;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    unique case (cmd.acc_op)
      AO_LOAD: acc <= prod_ext;
      AO_DET:  det <= diff;
      AO_NU:   nu  <= diff;
      AO_NV: begin
        nv      <= diff;
        det_neg <= det[ACC_W-1];
        adet    <= det[ACC_W-1] ? DET_W'(-det) : DET_W'(det);
      end
      default: ;
    endcase
  end

  assign singular = CMP_W'(adet) <= CMP_W'(limit);
  assign status   = '{singular: singular, div_done: div_done};

  lkws_div #(
    .NUM_W (ACC_W),
    .DEN_W (DET_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? nv : nu),
    .flip  (det_neg),
    .den   (adet),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.store_zero) begin
      res_x      <= '0;
      res_y      <= '0;
      res_solved <= 1'b0;
    end
    if (cmd.store_x) begin
      res_x <= quo;
    end
    if (cmd.store_y) begin
      res_y      <= quo;
      res_solved <= 1'b1;
    end
    if (cmd.load_out) begin
      out_data.flow_x <= res_x;
      out_data.flow_y <= res_y;
      out_data.solved <= res_solved;
    end
  end

endmodule

[hw/rtl/lkws_ctrl.sv]
// ----------------------------------------------------------------------------
// lkws_ctrl
// Controller: takes samples, steps the solve products, runs both divisions
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module lkws_ctrl
  import lkws_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_last,
  output logic     out_valid,
  input  logic     out_stall,
  output cmd_t     cmd,
  input  status_t  status
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIVX   = 3'd3;
  localparam logic [2:0] S_DIVY   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam logic [2:0] LAST_STEP = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] step;
  logic       out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MS_XX_YY;
    cmd.acc_op  = AO_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accumulate = 1'b1;
          if (in_last) begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        unique case (step)
          3'd0: begin cmd.mul_sel = MS_XX_YY; cmd.acc_op = AO_NONE; end
          3'd1: begin cmd.mul_sel = MS_XY_XY; cmd.acc_op = AO_LOAD; end
          3'd2: begin cmd.mul_sel = MS_XY_YT; cmd.acc_op = AO_DET;  end
          3'd3: begin cmd.mul_sel = MS_YY_XT; cmd.acc_op = AO_LOAD; end
          3'd4: begin cmd.mul_sel = MS_XY_XT; cmd.acc_op = AO_NU;   end
          3'd5: begin cmd.mul_sel = MS_XX_YT; cmd.acc_op = AO_LOAD; end
          default: begin cmd.mul_sel = MS_XX_YY; cmd.acc_op = AO_NV; end
        endcase
        if (step == LAST_STEP) begin
          cmd.clear  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.singular) begin
          cmd.store_zero = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVX;
        end
      end
      S_DIVX: begin
        if (status.div_done) begin
          cmd.store_x   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_sel = 1'b1;
        if (status.div_done) begin
          cmd.store_y = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state == S_MUL) ? step + 1'b1 : '0;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/lucas_kanade_window_solver.sv]
// ----------------------------------------------------------------------------
// lucas_kanade_window_solver
// Accumulates gradient products over a window and solves the 2x2 flow system.
// ----------------------------------------------------------------------------
// samples are taken one per cycle while in_stall is low; the window's last
// sample starts the solve: 7 multiply steps, 1 test, two divisions in the
//   shared bit-serial divider, output load
// singular windows skip both divisions; no samples taken meanwhile
// reset clears sums, sample count, singular_limit and the output valid
module lucas_kanade_window_solver
  import lkws_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  lkws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_data.last_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lkws_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule
